// ----- design/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
// No dependencies; every other file in the design depends on this package.
package ile_pkg;

  // Fixed field widths of the command and response words, and the default list depth
  localparam int POS_W         = 7;
  localparam int VAL_W         = 32;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_RESIZE = 3'd5,
    CMD_FIRST  = 3'd6,
    CMD_LAST   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP_PRIME,
    S_SHIFT_UP,
    S_PUT,
    S_DN_PRIME,
    S_SHIFT_DN,
    S_FILL,
    S_DONE
  } state_t;

  // Write data source for the element memory
  typedef enum logic [1:0] {
    WS_VAL,
    WS_RDATA,
    WS_ZERO
  } wsrc_t;

  // Address sources: the command's own index, or the walking pointers
  typedef enum logic {
    WA_ITEM,
    WA_PTR
  } waddr_t;

  typedef enum logic {
    RA_ITEM,
    RA_PTR
  } raddr_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_SET_UP,
    PTR_SET_DN,
    PTR_SET_FILL,
    PTR_READ_DEC,
    PTR_READ_INC,
    PTR_BOTH_DEC,
    PTR_BOTH_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_POS
  } cnt_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    st_load;
    logic    mem_wr;
    wsrc_t   wsrc;
    waddr_t  wa;
    logic    mem_rd;
    raddr_t  ra;
    ptr_op_t ptr_op;
    cnt_op_t cnt_op;
    logic    load_out;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic err;
    logic ins_at_end;
    logic ers_at_end;
    logic grow;
    logic up_last;
    logic dn_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/ile_in_if.sv -----
// Command channel of the indexed list engine: valid/ready plus the command word.
// Depends on ile_pkg for the command type and field widths.
interface ile_in_if;
  logic                              valid;
  logic                              ready;
  ile_pkg::cmd_t                     command;
  logic [ile_pkg::POS_W-1:0]         position;
  logic signed [ile_pkg::VAL_W-1:0]  value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

// ----- design/ile_out_if.sv -----
// Response channel of the indexed list engine: valid/ready plus the result word.
// Depends on ile_pkg for the status type and field widths.
interface ile_out_if;
  logic                              valid;
  logic                              ready;
  ile_pkg::status_t                  status;
  logic signed [ile_pkg::VAL_W-1:0]  read_value;
  logic [ile_pkg::POS_W-1:0]         count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

// ----- design/ile_dp.sv -----
// Datapath of the indexed list engine: element memory, count, walk pointers,
// status decode and the response register. Depends on ile_pkg and ile_out_if.
module ile_dp #(
  parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ile_pkg::cmd_t                     command,
  input  logic [ile_pkg::POS_W-1:0]         position,
  input  logic signed [ile_pkg::VAL_W-1:0]  value,
  input  ile_pkg::ctl_t                     ctl,
  output ile_pkg::sts_t                     sts,
  ile_out_if.source                         response
);
  import ile_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Latched command word
  cmd_t             cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  logic [CW-1:0]    count;
  logic [CW-1:0]    rptr;
  logic [CW-1:0]    wptr;
  logic [VAL_W-1:0] rdata;
  status_t          st_r;
  status_t          st;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_value;
  logic [POS_W-1:0] out_count;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [MW-1:0]    n_w;
  logic [MW-1:0]    pos_w;
  logic [MW-1:0]    depth_w;
  logic [MW-1:0]    wptr_w;
  logic [MW-1:0]    ridx_w;
  logic [MW-1:0]    widx_w;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             is_read;

  assign n_w     = MW'(count);
  assign pos_w   = MW'(pos_r);
  assign depth_w = MW'(DEPTH);
  assign wptr_w  = MW'(wptr);

  // Capture the command word on accept
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= command;
      pos_r <= position;
      val_r <= value;
    end
  end

  // Decode the result status against the current count
  always_comb begin
    st = ST_OK;
    unique case (cmd_r)
      CMD_APPEND: begin
        if (n_w >= depth_w) st = ST_FULL;
      end
      CMD_INSERT: begin
        if (pos_w > n_w) st = ST_RANGE;
        else if (n_w >= depth_w) st = ST_FULL;
      end
      CMD_ERASE, CMD_READ, CMD_WRITE: begin
        if (pos_w >= n_w) st = ST_RANGE;
      end
      CMD_RESIZE: begin
        if (pos_w > depth_w) st = ST_RANGE;
      end
      CMD_FIRST, CMD_LAST: begin
        if (n_w == '0) st = ST_EMPTY;
      end
    endcase
  end

  // Status flags toward the controller
  always_comb begin
    sts.cmd        = cmd_r;
    sts.err        = (st != ST_OK);
    sts.ins_at_end = (pos_w == n_w);
    sts.ers_at_end = ((pos_w + MW'(1)) == n_w);
    sts.grow       = (pos_w > n_w);
    sts.up_last    = (wptr_w == (pos_w + MW'(1)));
    sts.dn_last    = ((wptr_w + MW'(2)) == n_w);
    sts.fill_last  = ((wptr_w + MW'(1)) == pos_w);
    sts.out_free   = !out_valid || response.ready;
  end

  // Address and data selection for the element memory
  always_comb begin
    priority if (cmd_r == CMD_FIRST) begin
      ridx_w = '0;
    end else if (cmd_r == CMD_LAST) begin
      ridx_w = n_w - MW'(1);
    end else begin
      ridx_w = pos_w;
    end
    widx_w = (cmd_r == CMD_APPEND) ? n_w : pos_w;

    raddr = (ctl.ra == RA_PTR) ? rptr[AW-1:0] : ridx_w[AW-1:0];
    waddr = (ctl.wa == WA_PTR) ? wptr[AW-1:0] : widx_w[AW-1:0];

    unique case (ctl.wsrc)
      WS_VAL:   wdata = val_r;
      WS_RDATA: wdata = rdata;
      WS_ZERO:  wdata = '0;
      default:  wdata = '0;
    endcase
  end

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.mem_rd) begin
      rdata <= mem[raddr];
    end
  end

  // Walk pointers for shifting and zero fill
  always_ff @(posedge clk) begin
    unique case (ctl.ptr_op)
      PTR_HOLD: ;
      PTR_SET_UP: begin
        rptr <= count - CW'(1);
        wptr <= count;
      end
      PTR_SET_DN: begin
        wptr <= CW'(pos_w);
        rptr <= CW'(pos_w + MW'(1));
      end
      PTR_SET_FILL: begin
        wptr <= count;
      end
      PTR_READ_DEC: begin
        rptr <= rptr - CW'(1);
      end
      PTR_READ_INC: begin
        rptr <= rptr + CW'(1);
      end
      PTR_BOTH_DEC: begin
        rptr <= rptr - CW'(1);
        wptr <= wptr - CW'(1);
      end
      PTR_BOTH_INC: begin
        rptr <= rptr + CW'(1);
        wptr <= wptr + CW'(1);
      end
    endcase
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.cnt_op)
        CNT_HOLD: ;
        CNT_INC:  count <= count + CW'(1);
        CNT_DEC:  count <= count - CW'(1);
        CNT_POS:  count <= CW'(pos_w);
      endcase
    end
  end

  // Hold the decoded status for the response
  always_ff @(posedge clk) begin
    if (ctl.st_load) begin
      st_r <= st;
    end
  end

  assign is_read = (cmd_r == CMD_READ) || (cmd_r == CMD_FIRST) || (cmd_r == CMD_LAST);

  // Response register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status <= st_r;
      out_value  <= (st_r == ST_OK && is_read) ? rdata : '0;
      out_count  <= n_w[POS_W-1:0];
    end
  end

  assign response.valid      = out_valid;
  assign response.status     = out_status;
  assign response.read_value = out_value;
  assign response.count      = out_count;

endmodule

// ----- design/ile_ctrl.sv -----
// Controller of the indexed list engine: sequences each command over the
// datapath through ctl_t commands and sts_t status. Depends on ile_pkg.
module ile_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ile_pkg::sts_t sts,
  output ile_pkg::ctl_t ctl
);
  import ile_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      // Take no word while reset is applied
      S_IDLE: begin
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            ctl.latch  = 1'b1;
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ctl.st_load = 1'b1;
        if (sts.err) begin
          state_next = S_DONE;
        end else begin
          unique case (sts.cmd)
            CMD_APPEND, CMD_WRITE: begin
              ctl.mem_wr = 1'b1;
              ctl.wsrc   = WS_VAL;
              ctl.wa     = WA_ITEM;
              ctl.cnt_op = (sts.cmd == CMD_APPEND) ? CNT_INC : CNT_HOLD;
              state_next = S_DONE;
            end
            CMD_INSERT: begin
              if (sts.ins_at_end) begin
                ctl.mem_wr = 1'b1;
                ctl.wsrc   = WS_VAL;
                ctl.wa     = WA_ITEM;
                ctl.cnt_op = CNT_INC;
                state_next = S_DONE;
              end else begin
                ctl.ptr_op = PTR_SET_UP;
                state_next = S_UP_PRIME;
              end
            end
            CMD_ERASE: begin
              if (sts.ers_at_end) begin
                ctl.cnt_op = CNT_DEC;
                state_next = S_DONE;
              end else begin
                ctl.ptr_op = PTR_SET_DN;
                state_next = S_DN_PRIME;
              end
            end
            CMD_READ, CMD_FIRST, CMD_LAST: begin
              ctl.mem_rd = 1'b1;
              ctl.ra     = RA_ITEM;
              state_next = S_DONE;
            end
            CMD_RESIZE: begin
              if (sts.grow) begin
                ctl.ptr_op = PTR_SET_FILL;
                state_next = S_FILL;
              end else begin
                ctl.cnt_op = CNT_POS;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      // Shift up: read the word below, write it one place higher
      S_UP_PRIME: begin
        ctl.mem_rd = 1'b1;
        ctl.ra     = RA_PTR;
        ctl.ptr_op = PTR_READ_DEC;
        state_next = S_SHIFT_UP;
      end
      S_SHIFT_UP: begin
        ctl.mem_wr = 1'b1;
        ctl.wsrc   = WS_RDATA;
        ctl.wa     = WA_PTR;
        ctl.mem_rd = 1'b1;
        ctl.ra     = RA_PTR;
        ctl.ptr_op = PTR_BOTH_DEC;
        if (sts.up_last) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        ctl.mem_wr = 1'b1;
        ctl.wsrc   = WS_VAL;
        ctl.wa     = WA_ITEM;
        ctl.cnt_op = CNT_INC;
        state_next = S_DONE;
      end
      // Shift down: read the word above, write it one place lower
      S_DN_PRIME: begin
        ctl.mem_rd = 1'b1;
        ctl.ra     = RA_PTR;
        ctl.ptr_op = PTR_READ_INC;
        state_next = S_SHIFT_DN;
      end
      S_SHIFT_DN: begin
        ctl.mem_wr = 1'b1;
        ctl.wsrc   = WS_RDATA;
        ctl.wa     = WA_PTR;
        ctl.mem_rd = 1'b1;
        ctl.ra     = RA_PTR;
        ctl.ptr_op = PTR_BOTH_INC;
        if (sts.dn_last) begin
          ctl.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end
      end
      // Zero-fill grown slots one per cycle
      S_FILL: begin
        ctl.mem_wr = 1'b1;
        ctl.wsrc   = WS_ZERO;
        ctl.wa     = WA_PTR;
        ctl.ptr_op = PTR_BOTH_INC;
        if (sts.fill_last) begin
          ctl.cnt_op = CNT_POS;
          state_next = S_DONE;
        end
      end
      // Hand the word to the response register once it is free
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Never overwrite a response word that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> sts.out_free)
    else $error("response loaded while occupied");

  // An accepted command is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted command not executed");

  // Moves and fills run only for commands that passed their checks
  a_walk_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP || state == S_SHIFT_DN || state == S_FILL || state == S_PUT)
      |-> !sts.err)
    else $error("memory walk on a failed command");
`endif

endmodule

// ----- design/indexed_list_insert_erase.sv -----
// Indexed list engine: an accepted command is executed, then its response word is
// registered; the next command is taken once that word has been loaded.
// An insert that moves elements shifts them up one place per write, an erase
// shifts them down, a growing resize zero-fills each new slot; a held response word stalls.
// One command at a time, every move and fill going through the single write port.
// Reset clears count and control.
module indexed_list_insert_erase #(
  parameter int DEPTH = ile_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  ile_in_if.sink    request,
  ile_out_if.source response
);
  import ile_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic ready;

  assign request.ready = ready;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ile_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .command  (request.command),
    .position (request.position),
    .value    (request.value),
    .ctl      (ctl),
    .sts      (sts),
    .response (response)
  );

endmodule
